>>> src/assert_macros.svh
// Assertion shorthands for the checker file.
// Each macro samples on clk_i and is muted while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

>>> src/key1bf_pkg.sv
`default_nettype none

package key1bf_pkg;

  // Key table geometry: 18 subkeys followed by four 256-word S-boxes
  localparam int TblWords = 1042;
  localparam int TblAw    = 11;
  localparam int PLast    = 17;
  localparam int Rounds   = 16;

  localparam logic [TblAw-1:0] Sbox0Base = 11'h012;
  localparam logic [TblAw-1:0] Sbox1Base = 11'h112;
  localparam logic [TblAw-1:0] Sbox2Base = 11'h212;
  localparam logic [TblAw-1:0] Sbox3Base = 11'h312;

  // Refill after a keycode pass writes word pairs 0 .. 0x410/2
  localparam int FillLast     = 'h410;
  localparam int FillLastPair = FillLast / 2;
  localparam int FillAw       = TblAw - 1;

  // Output whitening subkeys
  localparam int WhiteEncLo = 16;
  localparam int WhiteEncHi = 17;
  localparam int WhiteDecLo = 1;
  localparam int WhiteDecHi = 0;

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_KSCHED = 2'd1,
    OP_ENC    = 2'd2,
    OP_DEC    = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    CFG_ID_CODE   = 2'd0,
    CFG_KEY_LEVEL = 2'd1,
    CFG_KEY_WORDS = 2'd2
  } cfg_idx_e;

  function automatic logic [31:0] swap32(input logic [31:0] v);
    return {v[7:0], v[15:8], v[23:16], v[31:24]};
  endfunction

endpackage

`default_nettype wire

>>> src/key1_blowfish_cipher_engine_top.sv
// Encrypt/decrypt: no new item is taken until the result is registered; each of the 16 rounds
//   steps through S_RS01, S_RS23 and S_RF for its five reads of the two-read-port key table.
// Table load: result valid the cycle after acceptance.
// Key schedule: each keycode pass runs 521 refill encryptions; key_level passes.
// Reset clears control and configuration (key_words to 2, the rest to 0); the key table
//   holds no defined contents until it is loaded or rebuilt by a key schedule.
`default_nettype none

module key1_blowfish_cipher_engine_top
  import key1bf_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire logic [1:0]            op_i,
  input  wire logic [TblAw-1:0]      table_index_i,
  input  wire logic [31:0]           table_word_i,
  input  wire logic [63:0]           block_in_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output logic [63:0]                block_out_o,
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [1:0]            cfg_index_i,
  input  wire logic [31:0]           cfg_data_i
);

  // Sequencer states
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_RP    = 4'd1;
  localparam logic [3:0] S_RS01  = 4'd2;
  localparam logic [3:0] S_RS23  = 4'd3;
  localparam logic [3:0] S_RF    = 4'd4;
  localparam logic [3:0] S_RW    = 4'd5;
  localparam logic [3:0] S_XRD   = 4'd6;
  localparam logic [3:0] S_XWR   = 4'd7;
  localparam logic [3:0] S_FHI   = 4'd8;
  localparam logic [3:0] S_FLO   = 4'd9;
  localparam logic [3:0] S_KNEXT = 4'd10;

  // Who asked for the running encryption
  localparam logic [1:0] CTX_USER  = 2'd0;
  localparam logic [1:0] CTX_PAIR1 = 2'd1;
  localparam logic [1:0] CTX_PAIR0 = 2'd2;
  localparam logic [1:0] CTX_FILL  = 2'd3;

  localparam logic [2:0] STEP_PASS1  = 3'd0;
  localparam logic [2:0] STEP_PASS2  = 3'd1;
  localparam logic [2:0] STEP_ADJUST = 3'd2;
  localparam logic [2:0] STEP_PASS3  = 3'd3;

  logic [3:0]        state_q;
  logic [1:0]        ctx_q;
  logic              dec_q;
  logic [3:0]        rnd_q;
  logic [31:0]       lft_q, rgt_q, z_q, f_q;
  logic [31:0]       kc_q [3];
  logic [2:0]        step_q;
  logic [4:0]        idx_q;
  logic [1:0]        sel_q;
  logic [FillAw-1:0] fill_q;
  logic [63:0]       out_q;
  logic              out_valid_q;
  logic [31:0]       id_code_q;
  logic [1:0]        key_level_q, key_words_q;

  // Key table memory: one write port, two registered read ports
  logic [31:0]       key_table_mem [TblWords];
  logic [31:0]       rd0_q, rd1_q;
  logic [TblAw-1:0]  ra0, ra1, wa;
  logic [31:0]       wd;
  logic              we;

  logic              in_acc, out_free;
  logic [4:0]        pk_cur, pk_nxt;
  logic [TblAw-1:0]  white_lo, white_hi;
  logic [31:0]       z_now, f_now;
  logic [63:0]       res;
  logic [1:0]        n_eff, sel_inc;

  assign in_ready_o  = (state_q == S_IDLE) && (!out_valid_q || out_ready_i);
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign block_out_o = out_q;
  assign cfg_ready_o = 1'b1;

  // Round key index, reversed for decrypt
  assign pk_cur = dec_q ? (5'(PLast) - {1'b0, rnd_q}) : {1'b0, rnd_q};
  assign pk_nxt = dec_q ? (5'(PLast) - {1'b0, rnd_q} - 5'd1) : ({1'b0, rnd_q} + 5'd1);
  assign white_lo = dec_q ? TblAw'(WhiteDecLo) : TblAw'(WhiteEncLo);
  assign white_hi = dec_q ? TblAw'(WhiteDecHi) : TblAw'(WhiteEncHi);

  // Shared round datapath
  assign z_now = rd0_q ^ lft_q;
  assign f_now = (f_q ^ rd0_q) + rd1_q;
  assign res   = {rgt_q ^ rd1_q, lft_q ^ rd0_q};

  // Keycode word selector wraps at key_words (zero acts as one)
  assign n_eff   = (key_words_q == 2'd0) ? 2'd1 : key_words_q;
  assign sel_inc = sel_q + 2'd1;

  // Read addresses
  always_comb begin
    ra0 = '0;
    ra1 = '0;
    case (state_q)
      S_RP: begin
        ra0 = TblAw'(pk_cur);
      end
      S_RS01: begin
        ra0 = Sbox0Base + TblAw'(z_now[31:24]);
        ra1 = Sbox1Base + TblAw'(z_now[23:16]);
      end
      S_RS23: begin
        ra0 = Sbox2Base + TblAw'(z_q[15:8]);
        ra1 = Sbox3Base + TblAw'(z_q[7:0]);
      end
      S_RF: begin
        if (rnd_q == 4'(Rounds - 1)) begin
          ra0 = white_lo;
          ra1 = white_hi;
        end else begin
          ra0 = TblAw'(pk_nxt);
        end
      end
      S_RW: begin
        ra0 = white_lo;
        ra1 = white_hi;
      end
      S_XRD: ra0 = TblAw'(idx_q);
      S_XWR: ra0 = TblAw'(idx_q + 5'd1);
      default: ;
    endcase
  end

  // Write port
  always_comb begin
    we = 1'b0;
    wa = '0;
    wd = '0;
    case (state_q)
      S_IDLE: begin
        if (in_acc && op_i == OP_LOAD && table_index_i < TblAw'(TblWords)) begin
          we = 1'b1;
          wa = table_index_i;
          wd = table_word_i;
        end
      end
      S_XWR: begin
        we = 1'b1;
        wa = TblAw'(idx_q);
        wd = rd0_q ^ swap32(kc_q[sel_q]);
      end
      S_FHI: begin
        we = 1'b1;
        wa = {fill_q, 1'b0};
        wd = lft_q;
      end
      S_FLO: begin
        we = 1'b1;
        wa = {fill_q, 1'b1};
        wd = rgt_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      key_table_mem[wa] <= wd;
    end
    rd0_q <= key_table_mem[ra0];
    rd1_q <= key_table_mem[ra1];
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      id_code_q   <= '0;
      key_level_q <= '0;
      key_words_q <= 2'd2;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_ID_CODE:   id_code_q   <= cfg_data_i;
        CFG_KEY_LEVEL: key_level_q <= cfg_data_i[1:0];
        CFG_KEY_WORDS: key_words_q <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ctx_q       <= CTX_USER;
      dec_q       <= 1'b0;
      rnd_q       <= '0;
      lft_q       <= '0;
      rgt_q       <= '0;
      z_q         <= '0;
      f_q         <= '0;
      kc_q[0]     <= '0;
      kc_q[1]     <= '0;
      kc_q[2]     <= '0;
      step_q      <= '0;
      idx_q       <= '0;
      sel_q       <= '0;
      fill_q      <= '0;
      out_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            case (op_i)
              OP_LOAD: begin
                out_q       <= '0;
                out_valid_q <= 1'b1;
              end
              OP_KSCHED: begin
                kc_q[0] <= id_code_q;
                kc_q[1] <= id_code_q >> 1;
                kc_q[2] <= id_code_q << 1;
                step_q  <= STEP_PASS1;
                state_q <= S_KNEXT;
              end
              default: begin
                lft_q   <= block_in_i[63:32];
                rgt_q   <= block_in_i[31:0];
                dec_q   <= (op_i == OP_DEC);
                ctx_q   <= CTX_USER;
                rnd_q   <= '0;
                state_q <= S_RP;
              end
            endcase
          end
        end
        S_KNEXT: begin
          case (step_q)
            STEP_PASS1, STEP_PASS2, STEP_PASS3: begin
              if ((step_q == STEP_PASS1 && key_level_q >= 2'd1) ||
                  (step_q == STEP_PASS2 && key_level_q >= 2'd2) ||
                  (step_q == STEP_PASS3 && key_level_q == 2'd3)) begin
                // encrypt pair (kc1 low, kc2 high)
                lft_q   <= kc_q[2];
                rgt_q   <= kc_q[1];
                dec_q   <= 1'b0;
                ctx_q   <= CTX_PAIR1;
                rnd_q   <= '0;
                state_q <= S_RP;
              end else begin
                step_q <= step_q + 3'd1;
              end
            end
            STEP_ADJUST: begin
              kc_q[1] <= kc_q[1] << 1;
              kc_q[2] <= kc_q[2] >> 1;
              step_q  <= step_q + 3'd1;
            end
            default: begin
              if (out_free) begin
                out_q       <= '0;
                out_valid_q <= 1'b1;
                state_q     <= S_IDLE;
              end
            end
          endcase
        end
        S_RP: state_q <= S_RS01;
        S_RS01: begin
          z_q     <= z_now;
          state_q <= S_RS23;
        end
        S_RS23: begin
          f_q     <= rd0_q + rd1_q;
          state_q <= S_RF;
        end
        S_RF: begin
          lft_q <= rgt_q ^ f_now;
          rgt_q <= z_q;
          if (rnd_q == 4'(Rounds - 1)) begin
            state_q <= S_RW;
          end else begin
            rnd_q   <= rnd_q + 4'd1;
            state_q <= S_RS01;
          end
        end
        S_RW: begin
          case (ctx_q)
            CTX_USER: begin
              if (out_free) begin
                out_q       <= res;
                out_valid_q <= 1'b1;
                state_q     <= S_IDLE;
              end
            end
            CTX_PAIR1: begin
              kc_q[1] <= res[31:0];
              kc_q[2] <= res[63:32];
              // encrypt pair (kc0 low, new kc1 high)
              lft_q   <= res[31:0];
              rgt_q   <= kc_q[0];
              ctx_q   <= CTX_PAIR0;
              rnd_q   <= '0;
              state_q <= S_RP;
            end
            CTX_PAIR0: begin
              kc_q[0] <= res[31:0];
              kc_q[1] <= res[63:32];
              idx_q   <= '0;
              sel_q   <= '0;
              state_q <= S_XRD;
            end
            default: begin
              lft_q   <= res[63:32];
              rgt_q   <= res[31:0];
              state_q <= S_FHI;
            end
          endcase
        end
        S_XRD: state_q <= S_XWR;
        S_XWR: begin
          if (idx_q == 5'(PLast)) begin
            // refill starts from a zero block
            lft_q   <= '0;
            rgt_q   <= '0;
            fill_q  <= '0;
            ctx_q   <= CTX_FILL;
            rnd_q   <= '0;
            state_q <= S_RP;
          end else begin
            idx_q <= idx_q + 5'd1;
            sel_q <= (sel_inc == n_eff) ? 2'd0 : sel_inc;
          end
        end
        S_FHI: state_q <= S_FLO;
        S_FLO: begin
          if (fill_q == FillAw'(FillLastPair)) begin
            step_q  <= step_q + 3'd1;
            state_q <= S_KNEXT;
          end else begin
            fill_q  <= fill_q + 1'b1;
            rnd_q   <= '0;
            state_q <= S_RP;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> src/key1bf_checker.sv
`default_nettype none
`include "assert_macros.svh"

module key1bf_checker
  import key1bf_pkg::*;
(
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              in_valid_i,
  input wire logic              in_ready_o,
  input wire logic [1:0]        op_i,
  input wire logic              out_valid_o,
  input wire logic              out_ready_i,
  input wire logic [63:0]       block_out_o
);

  logic in_acc;
  logic zero_res_q;

  assign in_acc = in_valid_i && in_ready_o;

  // Remember whether the item in flight gives an all-zero result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zero_res_q <= 1'b0;
    end else if (in_acc) begin
      zero_res_q <= (op_i == OP_LOAD) || (op_i == OP_KSCHED);
    end
  end

  // A table load answers in the next cycle
  `ASSERT_NEXT(a_load_answers, in_acc && op_i == OP_LOAD, out_valid_o)

  // Cipher and key schedule items keep the input closed while they run
  `ASSERT_NEXT(a_busy_after_long_op, in_acc && op_i != OP_LOAD, !in_ready_o)

  // Load and key schedule results are zero
  `ASSERT_IMPL(a_zero_result, out_valid_o && zero_res_q && !in_acc, block_out_o == 64'd0)

  // A result waiting on the consumer holds
  `ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(block_out_o))

endmodule

bind key1_blowfish_cipher_engine_top key1bf_checker u_key1bf_checker (.*);

`default_nettype wire
